// File: src/sgbjp_pkg.sv
// Shared types, codes and constants of the joypad packet port.
package sgbjp_pkg;

    localparam int STORE_DEPTH      = 128;
    localparam int STORE_AW         = $clog2(STORE_DEPTH);
    localparam int BYTES_PER_PACKET = 16;

    // transaction commands
    localparam logic [1:0] CMD_WRITE_P1   = 2'd0;
    localparam logic [1:0] CMD_READ_P1    = 2'd1;
    localparam logic [1:0] CMD_READ_BYTE  = 2'd2;
    localparam logic [1:0] CMD_SET_STATUS = 2'd3;

    // select line symbols
    localparam logic [1:0] SEL_PULSE = 2'b00;
    localparam logic [1:0] SEL_ONE   = 2'b01;
    localparam logic [1:0] SEL_ZERO  = 2'b10;
    localparam logic [1:0] SEL_NONE  = 2'b11;

    // receive phase codes as seen on the status port
    localparam logic [1:0] PHASE_CODE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_CODE_HEADER = 2'd1;
    localparam logic [1:0] PHASE_CODE_DATA   = 2'd2;
    localparam logic [1:0] PHASE_CODE_STOP   = 2'd3;

    localparam logic [4:0] CMD_PLAYERS = 5'h11;
    localparam logic [4:0] CMD_MASK_EN = 5'h17;

    localparam logic [7:0] P1_BTN_BASE  = 8'hD0;
    localparam logic [7:0] P1_DPAD_BASE = 8'hE0;
    localparam logic [7:0] P1_ALL_BASE  = 8'hF0;
    localparam logic [7:0] P1_RELEASED  = 8'hFF;

    localparam logic [3:0] PLAYER_ID_RESET = 4'hF;
    localparam logic [3:0] PLAYER_ID_WRAP  = 4'hB;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_STOP   = 4'b1000
    } t_phase;

    // how the result of a transaction gets its read data
    typedef enum logic [1:0] {
        KIND_IMM   = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_WRITE = 2'd2
    } t_kind;

    typedef struct packed {
        logic [4:0] command;
        logic       pending;
        logic [1:0] mask;
        logic [2:0] packets_left;
        logic [1:0] phase;
    } t_status;

    typedef struct packed {
        t_kind               kind;
        logic [7:0]          imm;
        logic [7:0]          bit_mask;
        logic                in_range;
        logic [STORE_AW-1:0] addr;
    } t_res;

    typedef struct packed {
        logic                rd_en;
        logic                clear;
        logic [STORE_AW-1:0] addr;
    } t_mem_req;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } t_mem_wr;

endpackage

// File: src/sgbjp_store.sv
// Packet store: synchronous RAM with per-entry valid bits and write forwarding.
module sgbjp_store
    import sgbjp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    input  t_mem_wr  i_wr,
    output logic [7:0] o_data
);

    logic [7:0]             r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_valid;
    logic [7:0]             r_rdata;
    logic                   r_rd_vld;
    logic                   r_fwd_hit;
    logic [7:0]             r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_req.rd_en) begin
            r_rdata    <= r_mem[i_req.addr];
            r_rd_vld   <= r_valid[i_req.addr];
            // write landing on the same edge as the read
            r_fwd_hit  <= i_wr.en && (i_wr.addr == i_req.addr);
            r_fwd_data <= i_wr.data;
        end
    end

    // a clear comes after any write retiring on the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.clear) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    assign o_data = r_fwd_hit ? r_fwd_data : (r_rd_vld ? r_rdata : 8'h00);

endmodule

// File: src/sgbjp_rx.sv
// Select register, serial packet receiver and P1 read logic.
module sgbjp_rx
    import sgbjp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_p1_value,
    input  logic [3:0] i_buttons_n,
    input  logic [3:0] i_dpad_n,
    input  logic [6:0] i_byte_index,
    input  logic       i_set_select,
    input  logic [1:0] i_set_value,
    output t_mem_req   o_req,
    output t_res       o_res,
    output t_status    o_status
);

    t_phase              r_phase, n_phase;
    logic [1:0]          r_select, n_select;
    logic [2:0]          r_pos, n_pos;
    logic [2:0]          r_length, n_length;
    logic [4:0]          r_command, n_command;
    logic [STORE_AW-1:0] r_wp, n_wp;
    logic [4:0]          r_bc, n_bc;
    logic [3:0]          r_player_id, n_player_id;
    logic [1:0]          r_players, n_players;
    logic [1:0]          r_mask, n_mask;
    logic                r_pending, n_pending;
    logic [1:0]          r_byte0, n_byte0;   // copy of store byte 0, bits 1:0

    logic [1:0] sel;
    logic       sym_bit;
    logic       sym_one;
    logic [3:0] id_next;
    logic [7:0] idx_ext;
    t_mem_req   req;

    function automatic logic [1:0] phase_code(t_phase ph);
        case (ph)
            PH_IDLE:   phase_code = PHASE_CODE_IDLE;
            PH_HEADER: phase_code = PHASE_CODE_HEADER;
            PH_DATA:   phase_code = PHASE_CODE_DATA;
            PH_STOP:   phase_code = PHASE_CODE_STOP;
            default:   phase_code = PHASE_CODE_IDLE;
        endcase
    endfunction

    assign sel     = i_p1_value[5:4];
    assign sym_one = (sel == SEL_ONE);
    assign sym_bit = (sel == SEL_ONE) || (sel == SEL_ZERO);
    assign idx_ext = {1'b0, i_byte_index};

    always_comb begin
        n_phase     = r_phase;
        n_select    = r_select;
        n_pos       = r_pos;
        n_length    = r_length;
        n_command   = r_command;
        n_wp        = r_wp;
        n_bc        = r_bc;
        n_player_id = r_player_id;
        n_players   = r_players;
        n_mask      = r_mask;
        n_pending   = r_pending;
        n_byte0     = r_byte0;
        id_next     = r_player_id - 4'd1;

        o_res.kind     = KIND_IMM;
        o_res.imm      = 8'h00;
        o_res.bit_mask = 8'h00;
        o_res.in_range = 1'b0;
        o_res.addr     = r_wp;
        req.rd_en      = 1'b0;
        req.clear      = 1'b0;
        req.addr       = r_wp;

        case (i_cmd)
            CMD_WRITE_P1: begin
                n_select = sel;
                case (r_phase)
                    PH_IDLE: begin
                        if (sel == SEL_PULSE) begin
                            n_pos = 3'd0;
                            if (r_length == 3'd0) begin
                                // new transfer
                                n_phase   = PH_HEADER;
                                req.clear = 1'b1;
                                n_wp      = '0;
                                n_command = 5'd0;
                                n_byte0   = 2'b00;
                            end else begin
                                n_phase = PH_DATA;
                                n_bc    = 5'd0;
                            end
                        end
                    end
                    PH_HEADER: begin
                        if (sym_bit) begin
                            if (r_pos < 3'd3) begin
                                n_length = r_length | (3'(sym_one) << r_pos[1:0]);
                            end else begin
                                n_command = r_command | (5'(sym_one) << (r_pos - 3'd3));
                            end
                            if (r_pos == 3'd7) begin
                                n_phase = PH_DATA;
                                n_pos   = 3'd0;
                                n_bc    = 5'd1;
                            end else begin
                                n_pos = r_pos + 3'd1;
                            end
                        end
                    end
                    PH_DATA: begin
                        if (sym_bit) begin
                            o_res.kind     = KIND_WRITE;
                            o_res.bit_mask = 8'(sym_one) << r_pos;
                            req.rd_en      = 1'b1;
                            if ((r_wp == '0) && (r_pos < 3'd2) && sym_one) begin
                                n_byte0[r_pos[0]] = 1'b1;
                            end
                            if (r_pos == 3'd7) begin
                                n_pos = 3'd0;
                                n_wp  = (r_wp == STORE_AW'(STORE_DEPTH - 1)) ? '0
                                                                             : r_wp + 1'b1;
                                n_bc  = r_bc + 5'd1;
                                // the packet ends once the updated count reaches a full packet
                                if (n_bc == 5'(BYTES_PER_PACKET)) begin
                                    n_phase = PH_STOP;
                                end
                            end else begin
                                n_pos = r_pos + 3'd1;
                            end
                        end
                    end
                    PH_STOP: begin
                        if (sel == SEL_ZERO) begin
                            n_phase  = PH_IDLE;
                            n_length = r_length - 3'd1;
                            if (r_length == 3'd1) begin
                                // last packet done: act on the command
                                if (r_command == CMD_PLAYERS) begin
                                    n_players = r_byte0;
                                end else if (r_command == CMD_MASK_EN) begin
                                    n_mask    = r_byte0;
                                    n_pending = 1'b1;
                                end else begin
                                    n_pending = 1'b1;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            CMD_READ_P1: begin
                case (r_select)
                    SEL_NONE: begin
                        if (r_players == 2'd0) begin
                            o_res.imm = P1_ALL_BASE | {4'h0, i_buttons_n | i_dpad_n};
                        end else begin
                            if (id_next == PLAYER_ID_WRAP) begin
                                n_player_id = PLAYER_ID_RESET;
                            end else begin
                                n_player_id = id_next;
                            end
                            o_res.imm = {4'h0, n_player_id};
                        end
                    end
                    SEL_ZERO:  o_res.imm = P1_DPAD_BASE | {4'h0, i_dpad_n};
                    SEL_ONE:   o_res.imm = P1_BTN_BASE | {4'h0, i_buttons_n};
                    default:   o_res.imm = P1_RELEASED;
                endcase
            end
            CMD_READ_BYTE: begin
                o_res.kind     = KIND_BYTE;
                o_res.in_range = (int'(i_byte_index) < STORE_DEPTH);
                o_res.addr     = idx_ext[STORE_AW-1:0];
                req.rd_en      = 1'b1;
                req.addr       = idx_ext[STORE_AW-1:0];
            end
            CMD_SET_STATUS: begin
                if (!i_set_select) begin
                    n_pending = i_set_value[0];
                end else begin
                    n_mask = i_set_value;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_req       = req;
        o_req.rd_en = req.rd_en && i_accept;
        o_req.clear = req.clear && i_accept;
    end

    assign o_status.command      = n_command;
    assign o_status.pending      = n_pending;
    assign o_status.mask         = n_mask;
    assign o_status.packets_left = n_length;
    assign o_status.phase        = phase_code(n_phase);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_select    <= 2'b00;
            r_pos       <= 3'd0;
            r_length    <= 3'd0;
            r_command   <= 5'd0;
            r_wp        <= '0;
            r_bc        <= 5'd0;
            r_player_id <= PLAYER_ID_RESET;
            r_players   <= 2'd0;
            r_mask      <= 2'd0;
            r_pending   <= 1'b0;
            r_byte0     <= 2'b00;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_select    <= n_select;
            r_pos       <= n_pos;
            r_length    <= n_length;
            r_command   <= n_command;
            r_wp        <= n_wp;
            r_bc        <= n_bc;
            r_player_id <= n_player_id;
            r_players   <= n_players;
            r_mask      <= n_mask;
            r_pending   <= n_pending;
            r_byte0     <= n_byte0;
        end
    end

endmodule

// File: src/sgb_joypad_packet_port.sv
// Top level of the joypad select register and serial packet port.
//
// One transaction per clock cycle while the result side keeps up. Every
// accepted transaction (P1 write, P1 read, packet byte read or status
// write) yields exactly one result, which is registered in the output
// register; the input side keeps accepting while that register is free or
// is being emptied in the same cycle, so throughput is one transaction per
// cycle. All receiver control state (phase, bit position, length, command,
// write pointer, player id and status flags) is updated at the edge where a
// transaction is accepted. The 128-byte packet store is a single RAM with a
// registered read: a data-phase P1 write reads the byte at the
// write pointer on acceptance and writes back the OR-ed bit when its
// result leaves the output register; a write retiring on the same edge as
// a new read is forwarded. Entries carry valid bits, so the store reads as
// zero after reset and after the clear at the start of each new transfer
// with no sweep and no stall. Bits 1:0 of store byte 0 are also kept in
// flip-flops so the end-of-transfer command acts without a RAM access.
module sgb_joypad_packet_port
    import sgbjp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_p1_value,
    input  logic [3:0] i_buttons_n,
    input  logic [3:0] i_dpad_n,
    input  logic [6:0] i_byte_index,
    input  logic       i_set_select,
    input  logic [1:0] i_set_value,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_data,
    output logic [4:0] o_command_code,
    output logic       o_command_pending,
    output logic [1:0] o_screen_mask,
    output logic [2:0] o_packets_left,
    output logic [1:0] o_receive_phase
);

    logic       accept;
    logic       depart;
    t_mem_req   req;
    t_mem_wr    wr;
    t_res       res;
    t_status    stat;
    logic [7:0] store_data;

    // output register
    logic    r_s1_valid;
    t_res    r_s1_res;
    t_status r_s1_stat;

    assign o_ready = !r_s1_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign depart  = r_s1_valid && i_ready;

    sgbjp_rx u_rx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_cmd        (i_cmd),
        .i_p1_value   (i_p1_value),
        .i_buttons_n  (i_buttons_n),
        .i_dpad_n     (i_dpad_n),
        .i_byte_index (i_byte_index),
        .i_set_select (i_set_select),
        .i_set_value  (i_set_value),
        .o_req        (req),
        .o_res        (res),
        .o_status     (stat)
    );

    // the bit write-back retires as its transaction leaves
    assign wr.en   = depart && (r_s1_res.kind == KIND_WRITE);
    assign wr.addr = r_s1_res.addr;
    assign wr.data = store_data | r_s1_res.bit_mask;

    sgbjp_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_wr    (wr),
        .o_data  (store_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (i_ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res  <= res;
            r_s1_stat <= stat;
        end
    end

    always_comb begin
        case (r_s1_res.kind)
            KIND_IMM:  o_read_data = r_s1_res.imm;
            KIND_BYTE: o_read_data = r_s1_res.in_range ? store_data : 8'h00;
            default:   o_read_data = 8'h00;
        endcase
    end

    assign o_valid           = r_s1_valid;
    assign o_command_code    = r_s1_stat.command;
    assign o_command_pending = r_s1_stat.pending;
    assign o_screen_mask     = r_s1_stat.mask;
    assign o_packets_left    = r_s1_stat.packets_left;
    assign o_receive_phase   = r_s1_stat.phase;

endmodule

// File: src/sgbjp_checker.sv
// Port-level checks for the joypad packet port, bound to the top level.
module sgbjp_checker
    import sgbjp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [1:0] i_cmd,
    input logic [7:0] i_p1_value,
    input logic [3:0] i_buttons_n,
    input logic [3:0] i_dpad_n,
    input logic [6:0] i_byte_index,
    input logic       i_set_select,
    input logic [1:0] i_set_value,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_read_data,
    input logic [4:0] o_command_code,
    input logic       o_command_pending,
    input logic [1:0] o_screen_mask,
    input logic [2:0] o_packets_left,
    input logic [1:0] o_receive_phase
);

    // no result survives reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // every accepted transaction shows its result in the next cycle
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> o_valid)
        else $error("accepted transaction gave no result");

    // P1 writes and status writes return zero data
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && ((i_cmd == CMD_WRITE_P1) || (i_cmd == CMD_SET_STATUS)))
        |=> (o_read_data == 8'h00))
        else $error("write transaction returned data");

    // a stalled result holds, store-sourced data included
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_read_data)
                                   && $stable(o_receive_phase)
                                   && $stable(o_packets_left)))
        else $error("stalled result changed");

endmodule

bind sgb_joypad_packet_port sgbjp_checker u_checker (.*);

// File: tb/sgbjp_checker.sv
// Scoreboard for the joypad packet port: mirrors the receiver and checks every result.
`timescale 1ns / 1ps

module sgbjp_scoreboard
    import sgbjp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_txn_valid,
    input  logic       i_txn_ready,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_p1_value,
    input  logic [3:0] i_buttons_n,
    input  logic [3:0] i_dpad_n,
    input  logic [6:0] i_byte_index,
    input  logic       i_set_select,
    input  logic [1:0] i_set_value,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [7:0] i_read_data,
    input  logic [4:0] i_command_code,
    input  logic       i_command_pending,
    input  logic [1:0] i_screen_mask,
    input  logic [2:0] i_packets_left,
    input  logic [1:0] i_receive_phase,
    output int         o_mismatches,
    output int         o_outstanding
);

    typedef struct packed {
        logic [7:0] read_data;
        logic [4:0] command_code;
        logic       command_pending;
        logic [1:0] screen_mask;
        logic [2:0] packets_left;
        logic [1:0] receive_phase;
    } t_port_result;

    // mirror of the receiver
    logic [1:0]          rx_phase;
    logic [1:0]          sel_lines;
    logic [2:0]          bit_pos;
    logic [2:0]          len_left;
    logic [4:0]          cmd_code;
    logic [STORE_AW-1:0] wr_ptr;
    logic [4:0]          byte_count;
    logic [7:0]          store_mirror [STORE_DEPTH];
    logic [3:0]          player;
    logic [1:0]          players;
    logic [1:0]          mask;
    logic                pending;

    t_port_result expected_results[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        o_mismatches++;
    endtask

    function automatic t_port_result predict_port_result(
        input logic [1:0] c, input logic [7:0] p1, input logic [3:0] btn,
        input logic [3:0] dp, input logic [6:0] idx, input logic ss,
        input logic [1:0] sv);
        t_port_result r;
        logic [1:0]   sel;
        logic         sym;
        logic [3:0]   nxt;
        r = '0;
        case (c)
            CMD_WRITE_P1: begin
                sel = p1[5:4];
                sel_lines = sel;
                // pulse and none only mean something while idle
                if (sel == SEL_ZERO || sel == SEL_ONE || rx_phase == PHASE_CODE_IDLE) begin
                    sym = (sel == SEL_ONE);
                    case (rx_phase)
                        PHASE_CODE_IDLE: begin
                            if (sel == SEL_PULSE) begin
                                bit_pos = '0;
                                if (len_left == 0) begin
                                    rx_phase = PHASE_CODE_HEADER;
                                    foreach (store_mirror[i]) store_mirror[i] = '0;
                                    wr_ptr = '0;
                                    cmd_code = '0;
                                end else begin
                                    rx_phase = PHASE_CODE_DATA;
                                    byte_count = '0;
                                end
                            end
                        end
                        PHASE_CODE_HEADER: begin
                            if (bit_pos < 3)
                                len_left = len_left | (3'(sym) << bit_pos);
                            else
                                cmd_code = cmd_code | (5'(sym) << (bit_pos - 3'd3));
                            if (bit_pos == 3'd7) begin
                                rx_phase = PHASE_CODE_DATA;
                                bit_pos = '0;
                                byte_count = 5'd1;
                            end else begin
                                bit_pos++;
                            end
                        end
                        PHASE_CODE_DATA: begin
                            store_mirror[wr_ptr] = store_mirror[wr_ptr] | (8'(sym) << bit_pos);
                            if (bit_pos == 3'd7) begin
                                bit_pos = '0;
                                wr_ptr = (int'(wr_ptr) == STORE_DEPTH - 1) ? '0
                                                                           : wr_ptr + 1'b1;
                                byte_count++;
                                if (byte_count == BYTES_PER_PACKET) rx_phase = PHASE_CODE_STOP;
                            end else begin
                                bit_pos++;
                            end
                        end
                        default: begin
                            // a one here keeps waiting for the stop bit
                            if (!sym) begin
                                rx_phase = PHASE_CODE_IDLE;
                                len_left--;
                                if (len_left == 0) begin
                                    if (cmd_code == CMD_PLAYERS) begin
                                        players = store_mirror[0][1:0];
                                    end else if (cmd_code == CMD_MASK_EN) begin
                                        mask = store_mirror[0][1:0];
                                        pending = 1'b1;
                                    end else begin
                                        pending = 1'b1;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            CMD_READ_P1: begin
                case (sel_lines)
                    SEL_NONE: begin
                        if (players == 0) begin
                            r.read_data = P1_ALL_BASE | {4'h0, btn} | {4'h0, dp};
                        end else begin
                            nxt = player - 4'd1;
                            if (nxt == PLAYER_ID_WRAP) nxt = PLAYER_ID_RESET;
                            player = nxt;
                            r.read_data = {4'h0, nxt};
                        end
                    end
                    SEL_ZERO: r.read_data = P1_DPAD_BASE | {4'h0, dp};
                    SEL_ONE:  r.read_data = P1_BTN_BASE | {4'h0, btn};
                    default:  r.read_data = P1_RELEASED;
                endcase
            end
            CMD_READ_BYTE: r.read_data = (int'(idx) < STORE_DEPTH) ? store_mirror[idx] : 8'h00;
            default: begin
                if (!ss) pending = sv[0];
                else mask = sv;
            end
        endcase
        r.command_code    = cmd_code;
        r.command_pending = pending;
        r.screen_mask     = mask;
        r.packets_left    = len_left;
        r.receive_phase   = rx_phase;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_port_result want;
        if (!i_rst_n) begin
            rx_phase   = PHASE_CODE_IDLE;
            sel_lines  = '0;
            bit_pos    = '0;
            len_left   = '0;
            cmd_code   = '0;
            wr_ptr     = '0;
            byte_count = '0;
            foreach (store_mirror[i]) store_mirror[i] = '0;
            player     = PLAYER_ID_RESET;
            players    = '0;
            mask       = '0;
            pending    = 1'b0;
            expected_results.delete();
        end else begin
            // a result leaves only after the edge that accepts it, so check before queueing
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding, read_data",
                                    i_read_data, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_read_data !== want.read_data)
                        report_mismatch("read_data", i_read_data, want.read_data);
                    if (i_command_code !== want.command_code)
                        report_mismatch("command_code", i_command_code, want.command_code);
                    if (i_command_pending !== want.command_pending)
                        report_mismatch("command_pending", i_command_pending,
                                        want.command_pending);
                    if (i_screen_mask !== want.screen_mask)
                        report_mismatch("screen_mask", i_screen_mask, want.screen_mask);
                    if (i_packets_left !== want.packets_left)
                        report_mismatch("packets_left", i_packets_left, want.packets_left);
                    if (i_receive_phase !== want.receive_phase)
                        report_mismatch("receive_phase", i_receive_phase, want.receive_phase);
                end
            end
            if (i_txn_valid && i_txn_ready)
                expected_results.push_back(predict_port_result(i_cmd, i_p1_value,
                    i_buttons_n, i_dpad_n, i_byte_index, i_set_select, i_set_value));
        end
        o_outstanding <= expected_results.size();
    end

endmodule

// File: tb/tb.sv
// Testbench top for the joypad packet port: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb
    import sgbjp_pkg::*;
();

    localparam int CLK_HALF      = 2;       // 4 ns period
    localparam int RESET_CYCLES  = 6;
    localparam int PASS_ITEMS    = 180;     // per back-pressure pattern
    localparam int LONG_HOLD     = 300;     // receiver stall long enough to fill the block
    localparam int DRAIN_SLACK   = 8;       // margin after the last result is back
    localparam int CYCLE_LIMIT   = 400000;

    logic       clk;
    logic       rst_n;
    logic       txn_valid;
    logic       txn_ready;
    logic [1:0] cmd;
    logic [7:0] p1_value;
    logic [3:0] buttons_n;
    logic [3:0] dpad_n;
    logic [6:0] byte_index;
    logic       set_select;
    logic [1:0] set_value;
    logic       res_valid;
    logic       res_ready;
    logic [7:0] read_data;
    logic [4:0] command_code;
    logic       command_pending;
    logic [1:0] screen_mask;
    logic [2:0] packets_left;
    logic [1:0] receive_phase;

    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_cycles;        // counted down by the receiver process
    int cycle_count;
    int accepted_items;
    int transfers_sent;
    int mismatches;
    int outstanding;

    sgb_joypad_packet_port dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (txn_valid),
        .o_ready           (txn_ready),
        .i_cmd             (cmd),
        .i_p1_value        (p1_value),
        .i_buttons_n       (buttons_n),
        .i_dpad_n          (dpad_n),
        .i_byte_index      (byte_index),
        .i_set_select      (set_select),
        .i_set_value       (set_value),
        .o_valid           (res_valid),
        .i_ready           (res_ready),
        .o_read_data       (read_data),
        .o_command_code    (command_code),
        .o_command_pending (command_pending),
        .o_screen_mask     (screen_mask),
        .o_packets_left    (packets_left),
        .o_receive_phase   (receive_phase)
    );

    sgbjp_scoreboard u_scoreboard (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_txn_valid       (txn_valid),
        .i_txn_ready       (txn_ready),
        .i_cmd             (cmd),
        .i_p1_value        (p1_value),
        .i_buttons_n       (buttons_n),
        .i_dpad_n          (dpad_n),
        .i_byte_index      (byte_index),
        .i_set_select      (set_select),
        .i_set_value       (set_value),
        .i_res_valid       (res_valid),
        .i_res_ready       (res_ready),
        .i_read_data       (read_data),
        .i_command_code    (command_code),
        .i_command_pending (command_pending),
        .i_screen_mask     (screen_mask),
        .i_packets_left    (packets_left),
        .i_receive_phase   (receive_phase),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends up here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timed out after %0d cycles with %0d results outstanding",
                 cycle_count, outstanding);
        $display("simulation failed");
        $finish;
    end

    // Result side. Drives ready once per falling edge: either the long hold-off
    // requested by the stimulus, or a random stall at the current rate.
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            res_ready <= 1'b0;
            hold_cycles--;
        end else begin
            res_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // One transaction. Entered and left at a falling edge; valid is only
    // touched once per edge, so back-to-back transactions keep it high.
    task automatic send_txn(input logic [1:0] c, input logic [7:0] p1,
                            input logic [3:0] btn, input logic [3:0] dp,
                            input logic [6:0] idx, input logic ss, input logic [1:0] sv);
        while ($urandom_range(99) < sender_idle_pct) begin
            txn_valid <= 1'b0;
            @(negedge clk);
        end
        txn_valid  <= 1'b1;
        cmd        <= c;
        p1_value   <= p1;
        buttons_n  <= btn;
        dpad_n     <= dp;
        byte_index <= idx;
        set_select <= ss;
        set_value  <= sv;
        @(posedge clk);
        while (!txn_ready) @(posedge clk);
        accepted_items++;
        @(negedge clk);
    endtask

    // P1 write carrying a select symbol; the unused bits and idle fields are noise.
    task automatic send_symbol(input logic [1:0] sel);
        send_txn(CMD_WRITE_P1, {2'($urandom), sel, 4'($urandom)}, 4'($urandom),
                 4'($urandom), 7'($urandom), 1'($urandom), 2'($urandom));
    endtask

    task automatic send_read_p1();
        send_txn(CMD_READ_P1, 8'($urandom), 4'($urandom), 4'($urandom),
                 7'($urandom), 1'($urandom), 2'($urandom));
    endtask

    // Store reads lean on the low bytes, where the packets actually land.
    task automatic send_read_byte();
        logic [6:0] idx;
        idx = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(20));
        send_txn(CMD_READ_BYTE, 8'($urandom), 4'($urandom), 4'($urandom),
                 idx, 1'($urandom), 2'($urandom));
    endtask

    task automatic send_status();
        send_txn(CMD_SET_STATUS, 8'($urandom), 4'($urandom), 4'($urandom),
                 7'($urandom), 1'($urandom), 2'($urandom));
    endtask

    // Transaction slipped between the symbols of a packet. Pulses and the
    // all-ones select should be ignored mid-packet; reads must not disturb it.
    task automatic send_stray();
        case ($urandom_range(4))
            0: send_read_p1();
            1: send_read_byte();
            2: send_symbol(SEL_NONE);
            3: send_symbol(SEL_PULSE);
            default: send_status();
        endcase
    endtask

    task automatic send_bit(input logic b);
        if ($urandom_range(99) < 4) send_stray();
        send_symbol(b ? SEL_ONE : SEL_ZERO);
    endtask

    task automatic send_byte(input logic [7:0] b);
        for (int i = 0; i < 8; i++) send_bit(b[i]);
    endtask

    // One packet: reset pulse, header on the first one only, data bytes LSB first,
    // then the stop bit, sometimes preceded by ones that must leave it waiting.
    task automatic send_packet(input bit first, input logic [2:0] len,
                               input logic [4:0] code);
        send_symbol(SEL_PULSE);
        if (first) begin
            for (int i = 0; i < 3; i++) send_bit(len[i]);
            for (int i = 0; i < 5; i++) send_bit(code[i]);
        end
        for (int i = 0; i < (first ? BYTES_PER_PACKET - 1 : BYTES_PER_PACKET); i++)
            send_byte(8'($urandom));
        while ($urandom_range(9) == 0) send_bit(1'b1);
        send_bit(1'b0);
    endtask

    // Sends the first packets of a transfer; a zero length stands for eight
    // packets, since the count wraps at the stop bit.
    task automatic send_transfer(input logic [2:0] len, input logic [4:0] code,
                                 input int packets);
        for (int p = 0; p < packets; p++) send_packet(p == 0, len, code);
        transfers_sent++;
    endtask

    // Probing while idle: latch a select pattern, then read P1 a few times
    // (walks the player id once a player count has been set), peek at the
    // store and sometimes poke the status flags.
    task automatic poke_around();
        int r;
        r = $urandom_range(2);
        send_symbol((r == 0) ? SEL_ONE : (r == 1) ? SEL_ZERO : SEL_NONE);
        repeat ($urandom_range(1, 5)) send_read_p1();
        send_read_byte();
        if ($urandom_range(1)) send_status();
    endtask

    // Random transactions between transfers. Writes never carry a pulse, so
    // an idle receiver only latches the select lines and framing holds.
    task automatic random_burst();
        logic [7:0] p1;
        repeat ($urandom_range(1, 6)) begin
            p1 = 8'($urandom);
            if (p1[5:4] == SEL_PULSE) p1[5:4] = SEL_NONE;
            send_txn(2'($urandom), p1, 4'($urandom), 4'($urandom),
                     7'($urandom), 1'($urandom), 2'($urandom));
        end
    endtask

    // Hold the input side off until every result is back, plus a little slack.
    task automatic wait_for_results();
        txn_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    initial begin
        int target;

        rst_n             = 1'b0;
        txn_valid         = 1'b0;
        cmd               = CMD_READ_P1;
        p1_value          = '0;
        buttons_n         = '0;
        dpad_n            = '0;
        byte_index        = '0;
        set_select        = 1'b0;
        set_value         = '0;
        res_ready         = 1'b0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        accepted_items    = 0;
        transfers_sent    = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: read-out in every select state, the all-ones select while idle
        // (ignored as a symbol), empty store at both ends, status writes to both fields.
        send_txn(CMD_READ_P1,    8'h00, 4'h0, 4'h0, 7'd0,   1'b0, 2'd0);
        send_txn(CMD_READ_BYTE,  8'hFF, 4'hF, 4'hF, 7'd0,   1'b1, 2'd3);
        send_txn(CMD_READ_BYTE,  8'h00, 4'h0, 4'h0, 7'd127, 1'b0, 2'd0);
        send_txn(CMD_WRITE_P1,   8'h30, 4'h0, 4'h0, 7'd0,   1'b0, 2'd0);
        send_txn(CMD_READ_P1,    8'h00, 4'h0, 4'h0, 7'd0,   1'b0, 2'd0);
        send_txn(CMD_READ_P1,    8'h00, 4'h1, 4'h2, 7'd0,   1'b0, 2'd0);
        send_txn(CMD_READ_P1,    8'h00, 4'hF, 4'hF, 7'd0,   1'b0, 2'd0);
        send_txn(CMD_WRITE_P1,   8'hDF, 4'hF, 4'hF, 7'd127, 1'b1, 2'd3);
        send_txn(CMD_READ_P1,    8'h00, 4'h0, 4'hF, 7'd0,   1'b0, 2'd0);
        send_txn(CMD_READ_P1,    8'h00, 4'hF, 4'h0, 7'd0,   1'b0, 2'd0);
        send_txn(CMD_WRITE_P1,   8'hEF, 4'h0, 4'h0, 7'd0,   1'b0, 2'd0);
        send_txn(CMD_READ_P1,    8'h00, 4'hF, 4'h0, 7'd0,   1'b0, 2'd0);
        send_txn(CMD_READ_P1,    8'h00, 4'h0, 4'hF, 7'd0,   1'b0, 2'd0);
        send_txn(CMD_WRITE_P1,   8'hFF, 4'h5, 4'hA, 7'd85,  1'b1, 2'd1);
        send_txn(CMD_READ_P1,    8'h00, 4'hA, 4'h5, 7'd0,   1'b0, 2'd0);
        send_txn(CMD_SET_STATUS, 8'h00, 4'h0, 4'h0, 7'd0,   1'b0, 2'd1);
        send_txn(CMD_SET_STATUS, 8'h00, 4'h0, 4'h0, 7'd0,   1'b0, 2'd2);
        send_txn(CMD_SET_STATUS, 8'h00, 4'h0, 4'h0, 7'd0,   1'b1, 2'd3);
        send_txn(CMD_SET_STATUS, 8'h00, 4'h0, 4'h0, 7'd0,   1'b1, 2'd0);
        send_txn(CMD_SET_STATUS, 8'h00, 4'h0, 4'h0, 7'd0,   1'b0, 2'd3);
        send_txn(CMD_SET_STATUS, 8'hFF, 4'hF, 4'hF, 7'd127, 1'b0, 2'd0);
        wait_for_results();

        // Random part in three back-pressure patterns: sender 21 / receiver 51,
        // then swapped, then none at all. The first two each carry a one-packet
        // transfer (player count, then mask enable) amid probing. The last opens
        // with a long receiver hold-off so the block backs up onto the sender,
        // and sends a zero-length transfer: the count wraps to seven at the first
        // stop bit and the second packet is a continuation. The run ends with
        // that transfer still open.
        for (int pass = 0; pass < 3; pass++) begin
            sender_idle_pct   = (pass == 0) ? 21 : (pass == 1) ? 51 : 0;
            receiver_idle_pct = (pass == 0) ? 51 : (pass == 1) ? 21 : 0;
            target = accepted_items + PASS_ITEMS;
            if (pass == 2) begin
                hold_cycles = LONG_HOLD;
                send_transfer(3'd0, 5'($urandom), 2);
            end else begin
                poke_around();
                send_transfer(3'd1, (pass == 0) ? CMD_PLAYERS : CMD_MASK_EN, 1);
            end
            while (accepted_items < target) begin
                if ($urandom_range(99) < 70) poke_around();
                else random_burst();
            end
            // sender pauses here until every result of this pattern is back
            wait_for_results();
        end

        $display("%0d transactions (%0d packet transfers) checked under three stall patterns",
                 accepted_items, transfers_sent);
        $display("in %0d cycles, with %0d field mismatches", cycle_count, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
